// ----- rtl/point_in_polygon_test_top_macros.svh -----
// Assertion macros for the point-in-polygon tester
`ifndef POINT_IN_POLYGON_TEST_TOP_MACROS_SVH
`define POINT_IN_POLYGON_TEST_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst
`define PIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst
`define PIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pip_pkg.sv -----
// Shared types and constants for the point-in-polygon tester
`timescale 1ns / 1ps

package pip_pkg;

  localparam int COORD_WIDTH      = 32;
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int CNT_OUT_W        = 11;
  localparam int REQ_W            = 2;
  localparam int STATUS_W         = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_QUERY = 2'd2
  } req_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_OPEN = 2'd2
  } status_t;

  // Operation select for the edge crossing unit
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_PRIME,
    OP_LOAD,
    OP_MUL_A,
    OP_MUL_B
  } pip_op_t;

  typedef struct packed {
    logic [REQ_W-1:0]              req_type;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
  } pip_req_t;

  typedef struct packed {
    logic                 inside_res;
    logic [CNT_OUT_W-1:0] crossing_count;
    logic [CNT_OUT_W-1:0] vertices_held;
    logic [STATUS_W-1:0]  status;
  } pip_res_t;

endpackage

// ----- rtl/pip_stream_if.sv -----
// Valid/ready channel carrying one payload per transfer
`timescale 1ns / 1ps

interface pip_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/pip_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/pip_cross_unit.sv -----
// Edge crossing test: operand setup, one shared multiplier, exact product compare
`timescale 1ns / 1ps

module pip_cross_unit (
  input  logic                                 clk,
  input  pip_pkg::pip_op_t                     op,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] qx,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] qy,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] cur_x,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] cur_y,
  output logic                                 hit
);
  import pip_pkg::*;

  localparam int W = COORD_WIDTH;

  function automatic logic [W-1:0] mag_of(input logic signed [W:0] v);
    logic [W:0] n;
    n = v[W] ? -v : v;
    return n[W-1:0];
  endfunction

  logic signed [W-1:0] prev_x, prev_y;
  logic                straddle;
  logic                sa, sc, sd;
  logic [W-1:0]        ma, mb, mc, md;
  logic                na, nb;
  logic [2*W-1:0]      pa, pb;

  logic signed [W:0] dxq, dxe, dy, cy;
  logic [W-1:0]      mul_l, mul_r;
  logic [2*W-1:0]    prod;
  logic              less;

  // Edge runs from prev (x2,y2) to cur (x1,y1); differences need one extra bit
  assign dxq = (W+1)'(qx) - (W+1)'(prev_x);
  assign dxe = (W+1)'(cur_x) - (W+1)'(prev_x);
  assign dy  = (W+1)'(cur_y) - (W+1)'(prev_y);
  assign cy  = (W+1)'(qy) - (W+1)'(prev_y);

  assign mul_l = (op == OP_MUL_B) ? mc : ma;
  assign mul_r = (op == OP_MUL_B) ? md : mb;
  assign prod  = (2*W)'(mul_l) * (2*W)'(mul_r);

  always_ff @(posedge clk) begin
    unique case (op)
      OP_PRIME: begin
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
      OP_LOAD: begin
        prev_x   <= cur_x;
        prev_y   <= cur_y;
        straddle <= (cur_y > qy) != (prev_y > qy);
        sa       <= dxq[W];
        ma       <= mag_of(dxq);
        // dy is made positive; its sign moves onto cy
        mb       <= mag_of(dy);
        sc       <= cy[W] ^ dy[W];
        mc       <= mag_of(cy);
        sd       <= dxe[W];
        md       <= mag_of(dxe);
      end
      OP_MUL_A: begin
        pa <= prod;
        na <= sa && (ma != '0) && (mb != '0);
      end
      OP_MUL_B: begin
        pb <= prod;
        nb <= (sc ^ sd) && (mc != '0) && (md != '0);
      end
      OP_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  // (qx-x2)*|dy| < cy*sign(dy)*(x1-x2), products held as sign and magnitude
  always_comb begin
    if (na != nb) begin
      less = na;
    end else if (na) begin
      less = pa > pb;
    end else begin
      less = pa < pb;
    end
    hit = straddle && less;
  end

endmodule

// ----- rtl/point_in_polygon_test_top.sv -----
// Point-in-polygon tester: vertex store, edge walk sequencer and result register
// Usage:
//   req carries req_type, x_coord, y_coord (signed Q16.16). A clear empties the
//   vertex store, an add appends one vertex, a query tests one point against
//   the implicitly closed polygon by the even-odd ray crossing rule.
//   res carries one result per request: inside_res, crossing_count,
//   vertices_held and status (ok, store full and vertex dropped, open shape).
//   cfg writes closed_shape (reset 1); it is always ready. It must be written
//   only while the block is idle; the block itself does not enforce this.
// Timing:
//   Clear, add and unused codes: result valid the cycle after the transfer;
//   one request per cycle while the receiver keeps up.
//   Query on n stored vertices: a prime read of the last vertex, then per
//   edge one store read plus two passes through the single 32x32 multiplier
//   and a compare, then the result (n = 0 or open shape: registered at the
//   transfer, as for a clear). req is not ready while a query walks the edges.
// Reset: vertex count 0, closed_shape 1, no result pending.
// Stall: a finished result waits in the output register; a new request is
//   taken in the same cycle that the waiting result transfers.
`timescale 1ns / 1ps
`include "point_in_polygon_test_top_macros.svh"

module point_in_polygon_test_top #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pip_stream_if.sink   req,
  pip_stream_if.source res,
  pip_stream_if.sink   cfg
);
  import pip_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_OPER,
    S_MUL_A,
    S_MUL_B,
    S_CMP,
    S_DONE
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        vcount;
  logic [CNT_W-1:0]        xcount;
  logic [AW-1:0]           idx;
  logic                    closed;
  logic signed [COORD_WIDTH-1:0] qx, qy;
  logic                    res_valid;
  pip_res_t                res_data;

  logic                    out_free, in_acc, full;
  logic [AW-1:0]           last_idx;
  logic [CNT_W-1:0]        vcount_inc;
  logic                    we, re;
  logic [AW-1:0]           raddr;
  logic [COORD_WIDTH-1:0]  rd_x, rd_y;
  pip_op_t                 op;
  logic                    hit;

  assign out_free   = !res_valid || res.ready;
  assign req.ready  = (state == S_IDLE) && out_free;
  assign in_acc     = req.valid && req.ready;
  assign full       = vcount == CNT_W'(MAX_VERTICES);
  assign last_idx   = AW'(vcount - 1'b1);
  assign vcount_inc = vcount + 1'b1;
  assign cfg.ready  = 1'b1;
  assign res.valid  = res_valid;
  assign res.data   = res_data;

  // Store access and crossing unit control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    raddr = last_idx;
    op    = OP_IDLE;
    unique case (state)
      S_IDLE: begin
        we = in_acc && (req.data.req_type == REQ_ADD) && !full;
        // first edge pairs vertex 0 with the last vertex
        re = in_acc && (req.data.req_type == REQ_QUERY) && closed && (vcount != '0);
      end
      S_PRIME: begin
        re    = 1'b1;
        raddr = '0;
        op    = OP_PRIME;
      end
      S_OPER: begin
        re    = idx != last_idx;
        raddr = idx + 1'b1;
        op    = OP_LOAD;
      end
      S_MUL_A: op = OP_MUL_A;
      S_MUL_B: op = OP_MUL_B;
      S_CMP, S_DONE: op = OP_IDLE;
      default: op = OP_IDLE;
    endcase
  end

  pip_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_VERTICES)) u_vertex_x_store (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(vcount)),
    .wdata (req.data.x_coord),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_x)
  );

  pip_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_VERTICES)) u_vertex_y_store (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(vcount)),
    .wdata (req.data.y_coord),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_y)
  );

  pip_cross_unit u_cross (
    .clk   (clk),
    .op    (op),
    .qx    (qx),
    .qy    (qy),
    .cur_x ($signed(rd_x)),
    .cur_y ($signed(rd_y)),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vcount    <= '0;
      closed    <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        closed <= cfg.data;
      end
      if (res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            res_valid               <= 1'b1;
            res_data.inside_res     <= 1'b0;
            res_data.crossing_count <= '0;
            res_data.vertices_held  <= CNT_OUT_W'(vcount);
            res_data.status         <= ST_OK;
            qx                      <= req.data.x_coord;
            qy                      <= req.data.y_coord;
            xcount                  <= '0;
            case (req.data.req_type)
              REQ_CLEAR: begin
                vcount                 <= '0;
                res_data.vertices_held <= '0;
              end
              REQ_ADD: begin
                if (full) begin
                  res_data.status <= ST_FULL;
                end else begin
                  vcount                 <= vcount_inc;
                  res_data.vertices_held <= CNT_OUT_W'(vcount_inc);
                end
              end
              REQ_QUERY: begin
                if (!closed) begin
                  res_data.status <= ST_OPEN;
                end else if (vcount != '0) begin
                  res_valid <= 1'b0;
                  state     <= S_PRIME;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PRIME: begin
          idx   <= '0;
          state <= S_OPER;
        end
        S_OPER:  state <= S_MUL_A;
        S_MUL_A: state <= S_MUL_B;
        S_MUL_B: state <= S_CMP;
        S_CMP: begin
          if (hit) begin
            xcount <= xcount + 1'b1;
          end
          if (idx == last_idx) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_OPER;
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_valid               <= 1'b1;
            res_data.inside_res     <= xcount[0];
            res_data.crossing_count <= CNT_OUT_W'(xcount);
            res_data.vertices_held  <= CNT_OUT_W'(vcount);
            res_data.status         <= ST_OK;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PIP_ASSERT_NOW(a_count_bound, 1'b1, vcount <= CNT_W'(MAX_VERTICES), "vertex count over capacity")
  `PIP_ASSERT_NEXT(a_add_grows, in_acc && (req.data.req_type == REQ_ADD) && !full, vcount == $past(vcount) + 1'b1, "accepted add did not grow store")
  `PIP_ASSERT_NOW(a_walk_in_range, state == S_OPER, CNT_W'(idx) < vcount, "edge walk beyond stored vertices")
  `PIP_ASSERT_NOW(a_cross_bound, state == S_DONE, xcount <= vcount, "more crossings than edges")

endmodule
